/* sv/sslts_pkg.sv */
package sslts_pkg;

	// Pulse widths are carried in microseconds.
	localparam int PULSE_BITS = 12;
	localparam int NUM_BITS   = PULSE_BITS + 1;
	localparam int QUANT_BITS = 6;
	localparam int CFG_BITS   = 8;
	localparam int CFG_IDX_BITS = 3;

	localparam int IN_FIELD_W  = 1 + 2 + 2 + 16 + 2;
	localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = 6 + 2 * PULSE_BITS;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef logic [PULSE_BITS-1:0] pulse_t;
	typedef logic [QUANT_BITS-1:0] quant_t;

	localparam pulse_t PULSE_MAX     = {PULSE_BITS{1'b1}};
	localparam pulse_t CLAW_CLOSE_US = pulse_t'(1833);
	localparam pulse_t CLAW_OPEN_US  = pulse_t'(500);
	localparam pulse_t JOINT_UP_US   = pulse_t'(1833);
	localparam pulse_t JOINT_DOWN_US = pulse_t'(944);
	localparam pulse_t JOINT_HOME_US = pulse_t'(1500);
	localparam logic [3:0] UI_PERIOD = 4'd10;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CLAW_INTERVAL  = 3'd0,
		CFG_CLAW_STEP      = 3'd1,
		CFG_CLAW_DEADBAND  = 3'd2,
		CFG_CLAW_QUANT     = 3'd3,
		CFG_JOINT_INTERVAL = 3'd4,
		CFG_JOINT_STEP     = 3'd5,
		CFG_JOINT_DEADBAND = 3'd6,
		CFG_JOINT_QUANT    = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUANT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic quant_busy;
		logic out_free;
	} dp_stat_t;

endpackage

/* sv/servo_slew_limiter_tick_scheduler_top.sv */
// Servo slew limiter and 1 ms tick scheduler. Each transaction on the slave
// stream is either a tick (tuser low) or the start of a timed rotation (tuser
// high), and each gives exactly one transaction on the master stream. A tick
// raises the display-refresh flag every tenth tick, advances a running timed
// rotation and reports its stop with the channel, maps the manual joint and
// claw directions to their end-point targets, and at the configured interval
// moves each servo pulse towards its target by at most one step, snapping to
// the target inside the dead band. A pulse that is written is rounded to the
// channel's quantum by a 13-bit restoring divider that yields one quotient
// bit per cycle, followed by a multiply; the claw and joint dividers run side
// by side. The result is then loaded into the output register, and the next
// item is taken once that load is done, even while the result still waits
// on the master side. A pulse field reads zero when its write flag is low,
// and the stop channel reads zero without a stop. Configuration writes are
// always taken, and should be made while no item is in flight.
module servo_slew_limiter_tick_scheduler_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// mode
	input  logic                               s_tuser,
	// manual_mode, joint_dir, claw_dir, rotate_ms, rotate_channel, zero fill
	input  logic [sslts_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// ui_update, rotate_stop, stop_channel, claw_write, claw_pulse,
	// joint_write, joint_pulse, zero fill
	output logic [sslts_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sslts_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sslts_pkg::CFG_BITS-1:0]     cfg_data
);
	import sslts_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Registers are written in any cycle; the datapath reads them only per item.
	assign cfg_ready = 1'b1;

	sslts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sslts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* sv/sslts_quant.sv */
module sslts_quant (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sslts_pkg::pulse_t  x,
	input  sslts_pkg::quant_t  q,
	output logic               busy,
	output sslts_pkg::pulse_t  result
);
	import sslts_pkg::*;

	localparam int CNT_W  = $clog2(NUM_BITS + 1);
	localparam int PROD_W = NUM_BITS + QUANT_BITS;

	logic [NUM_BITS-1:0] num_q;
	quant_t              rem_q;
	quant_t              div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	pulse_t              result_q;

	quant_t              q_eff;
	logic [NUM_BITS-1:0] num_start;
	logic [QUANT_BITS:0] rem_sh;
	logic [QUANT_BITS:0] rem_diff;
	logic                ge;
	logic [PROD_W-1:0]   prod;

	assign q_eff     = (q == '0) ? quant_t'(1) : q;
	assign num_start = NUM_BITS'(x) + NUM_BITS'(q_eff >> 1);
	assign rem_sh    = {rem_q, num_q[NUM_BITS-1]};
	assign rem_diff  = rem_sh - {1'b0, div_q};
	assign ge        = rem_sh >= {1'b0, div_q};
	assign prod      = PROD_W'(num_q) * PROD_W'(div_q);

	// Restoring division, one quotient bit per cycle; the quotient shifts into num_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_BITS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num_start;
			rem_q <= '0;
			div_q <= q_eff;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? rem_diff[QUANT_BITS-1:0] : rem_sh[QUANT_BITS-1:0];
				num_q <= {num_q[NUM_BITS-2:0], ge};
			end else begin
				result_q <= (prod > PROD_W'(PULSE_MAX)) ? PULSE_MAX : prod[PULSE_BITS-1:0];
			end
		end
	end

	assign busy   = busy_q;
	assign result = result_q;

endmodule

/* sv/sslts_dp.sv */
module sslts_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sslts_pkg::dp_cmd_t                cmd,
	output sslts_pkg::dp_stat_t               stat,
	input  logic                              s_tuser,
	input  logic [sslts_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                              cfg_valid,
	input  logic [sslts_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sslts_pkg::CFG_BITS-1:0]    cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sslts_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import sslts_pkg::*;

	typedef struct packed {
		pulse_t cur;
		logic   moving;
	} slew_t;

	typedef struct packed {
		logic       ui;
		logic       stop;
		logic [1:0] ch;
		logic       cw;
		logic       jw;
	} flags_t;

	function automatic slew_t slew_step(input pulse_t cur, input pulse_t tgt,
			input logic [7:0] step, input logic [7:0] band);
		pulse_t d;
		pulse_t dd;
		slew_t  r;
		d = (cur > tgt) ? (cur - tgt) : (tgt - cur);
		dd = (d > pulse_t'(step)) ? pulse_t'(step) : d;
		if (d <= pulse_t'(band)) begin
			r.cur    = tgt;
			r.moving = 1'b0;
		end else begin
			r.cur    = (cur < tgt) ? (cur + dd) : (cur - dd);
			r.moving = 1'b1;
		end
		return r;
	endfunction

	// Configuration registers.
	logic [7:0] claw_interval_q, claw_step_q, claw_band_q;
	logic [7:0] joint_interval_q, joint_step_q, joint_band_q;
	quant_t     claw_quant_q, joint_quant_q;

	// Block state.
	logic [3:0]  ui_cnt_q;
	logic [7:0]  claw_cnt_q, joint_cnt_q;
	pulse_t      claw_cur_q, claw_tgt_q, joint_cur_q, joint_tgt_q, joint_last_q;
	logic        claw_mov_q, joint_mov_q;
	logic        rot_q;
	logic [15:0] elapsed_q, limit_q;
	logic [1:0]  chan_q;
	flags_t      flags_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Input fields.
	logic        mode, manual;
	logic [1:0]  joint_dir, claw_dir;
	logic [15:0] rotate_ms;
	logic [1:0]  rotate_channel;

	logic [3:0]  ui_inc;
	logic        ui_hit;
	logic [15:0] el_inc;
	logic        stop;
	pulse_t      jt_m, ct_m;
	logic        jm_m, cm_m;
	logic [7:0]  claw_inc, joint_inc;
	logic        claw_fire, joint_fire;
	logic        cw, jw;
	slew_t       claw_sl, joint_sl;
	logic        claw_busy, joint_busy;
	pulse_t      claw_res, joint_res;
	pulse_t      claw_pulse, joint_pulse;

	assign mode           = s_tuser;
	assign manual         = s_tdata[0];
	assign joint_dir      = s_tdata[2:1];
	assign claw_dir       = s_tdata[4:3];
	assign rotate_ms      = s_tdata[20:5];
	assign rotate_channel = s_tdata[22:21];

	always_comb begin
		ui_inc = ui_cnt_q + 4'd1;
		ui_hit = ui_inc >= UI_PERIOD;
		el_inc = elapsed_q + 16'd1;
		stop   = rot_q && (el_inc >= limit_q);

		jt_m = joint_tgt_q;
		jm_m = joint_mov_q;
		ct_m = claw_tgt_q;
		cm_m = claw_mov_q;
		if (manual) begin
			if (joint_dir == 2'b01) begin
				jt_m = JOINT_UP_US;
				jm_m = 1'b1;
			end else if (joint_dir[1]) begin
				jt_m = JOINT_DOWN_US;
				jm_m = 1'b1;
			end else begin
				jt_m = joint_cur_q;
				jm_m = 1'b0;
			end
			if (claw_dir == 2'b01) begin
				ct_m = CLAW_CLOSE_US;
				cm_m = 1'b1;
			end else if (claw_dir[1]) begin
				ct_m = CLAW_OPEN_US;
				cm_m = 1'b1;
			end
		end

		claw_inc   = claw_cnt_q + 8'd1;
		joint_inc  = joint_cnt_q + 8'd1;
		claw_fire  = claw_inc >= claw_interval_q;
		joint_fire = joint_inc >= joint_interval_q;
		cw         = claw_fire && cm_m;
		jw         = joint_fire && jm_m;
		claw_sl    = slew_step(claw_cur_q, ct_m, claw_step_q, claw_band_q);
		joint_sl   = slew_step(joint_cur_q, jt_m, joint_step_q, joint_band_q);
	end

	sslts_quant u_claw_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept),
		.x      (claw_sl.cur),
		.q      (claw_quant_q),
		.busy   (claw_busy),
		.result (claw_res)
	);

	sslts_quant u_joint_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept),
		.x      (joint_sl.cur),
		.q      (joint_quant_q),
		.busy   (joint_busy),
		.result (joint_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claw_interval_q  <= 8'd20;
			claw_step_q      <= 8'd10;
			claw_band_q      <= 8'd3;
			claw_quant_q     <= quant_t'(5);
			joint_interval_q <= 8'd20;
			joint_step_q     <= 8'd10;
			joint_band_q     <= 8'd2;
			joint_quant_q    <= quant_t'(2);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CLAW_INTERVAL:  claw_interval_q  <= cfg_data;
				CFG_CLAW_STEP:      claw_step_q      <= cfg_data;
				CFG_CLAW_DEADBAND:  claw_band_q      <= cfg_data;
				CFG_CLAW_QUANT:     claw_quant_q     <= cfg_data[QUANT_BITS-1:0];
				CFG_JOINT_INTERVAL: joint_interval_q <= cfg_data;
				CFG_JOINT_STEP:     joint_step_q     <= cfg_data;
				CFG_JOINT_DEADBAND: joint_band_q     <= cfg_data;
				CFG_JOINT_QUANT:    joint_quant_q    <= cfg_data[QUANT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ui_cnt_q     <= '0;
			claw_cnt_q   <= '0;
			joint_cnt_q  <= '0;
			claw_cur_q   <= CLAW_OPEN_US;
			claw_tgt_q   <= CLAW_OPEN_US;
			claw_mov_q   <= 1'b0;
			joint_cur_q  <= JOINT_HOME_US;
			joint_tgt_q  <= JOINT_HOME_US;
			joint_mov_q  <= 1'b0;
			joint_last_q <= JOINT_HOME_US;
			rot_q        <= 1'b0;
			elapsed_q    <= '0;
			limit_q      <= '0;
			chan_q       <= '0;
			flags_q      <= '0;
		end else begin
			if (cmd.accept && mode) begin
				rot_q     <= 1'b1;
				elapsed_q <= '0;
				limit_q   <= rotate_ms;
				chan_q    <= rotate_channel;
				flags_q   <= '0;
			end else if (cmd.accept) begin
				ui_cnt_q <= ui_hit ? 4'd0 : ui_inc;
				if (rot_q) begin
					elapsed_q <= el_inc;
					if (stop) begin
						rot_q <= 1'b0;
					end
				end
				claw_cnt_q  <= claw_fire ? 8'd0 : claw_inc;
				joint_cnt_q <= joint_fire ? 8'd0 : joint_inc;
				claw_tgt_q  <= ct_m;
				claw_mov_q  <= cm_m;
				if (cw) begin
					claw_cur_q <= claw_sl.cur;
					claw_mov_q <= claw_sl.moving;
				end
				joint_tgt_q <= jt_m;
				joint_mov_q <= jm_m;
				if (jw) begin
					joint_cur_q <= joint_sl.cur;
					joint_mov_q <= joint_sl.moving;
				end else if (joint_fire) begin
					joint_cur_q <= joint_last_q;
					joint_tgt_q <= joint_last_q;
				end
				flags_q <= '{ui: ui_hit, stop: stop, ch: stop ? chan_q : 2'd0,
					cw: cw, jw: jw};
			end
			if (cmd.load_out && flags_q.jw) begin
				joint_last_q <= joint_res;
			end
		end
	end

	assign claw_pulse  = flags_q.cw ? claw_res : '0;
	assign joint_pulse = flags_q.jw ? joint_res : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= OUT_DATA_W'({joint_pulse, flags_q.jw, claw_pulse, flags_q.cw,
				flags_q.ch, flags_q.stop, flags_q.ui});
		end
	end

	assign stat.quant_busy = claw_busy || joint_busy;
	assign stat.out_free   = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_data_q;

endmodule

/* sv/sslts_ctrl.sv */
module sslts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sslts_pkg::dp_stat_t  stat,
	output sslts_pkg::dp_cmd_t   cmd
);
	import sslts_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_QUANT;
				end
			end
			ST_QUANT: begin
				if (!stat.quant_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_DONE: begin
				cmd.load_out = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* sv/sslts_chk.sv */
module sslts_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic                               s_tuser,
	input  logic [sslts_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [sslts_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [sslts_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sslts_pkg::CFG_BITS-1:0]     cfg_data
);
	import sslts_pkg::*;

	// A waiting result holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	// One item at a time: no second transaction straight after an accepted one.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again in the cycle after acceptance");

	// The stop channel is only reported with a stop.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1] || (m_tdata[3:2] == 2'd0))
		else $error("stop channel without stop");

	// Pulse fields are zero unless their write flag is set.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4] || (m_tdata[4+PULSE_BITS:5] == '0)) &&
			(m_tdata[5+PULSE_BITS] || (m_tdata[5+2*PULSE_BITS:6+PULSE_BITS] == '0)))
		else $error("pulse reported without write flag");

endmodule

bind servo_slew_limiter_tick_scheduler_top sslts_chk u_sslts_chk (.*);

/* tb/servo_tick_checker.sv */
`timescale 1ns / 100ps

// Watches the three channels of the slew limiter and tick scheduler. It
// predicts every result and checks each accepted result against the oldest
// prediction. Counters go out with a nonblocking update, so a reader at the
// same edge always sees the value from the edge before.
module servo_tick_checker
	import sslts_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic                    s_tuser,
	input  logic [IN_DATA_W-1:0]    s_tdata,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [OUT_DATA_W-1:0]   m_tdata,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output int unsigned             fail_count,
	output int unsigned             pending,
	output int unsigned             ticks_seen,
	output int unsigned             starts_seen,
	output int unsigned             stops_seen,
	output int unsigned             claw_writes,
	output int unsigned             joint_writes
);

	localparam logic MODE_START = 1'b1;

	typedef struct packed {
		logic       ui;
		logic       stop;
		logic [1:0] stop_ch;
		logic       cw;
		pulse_t     cp;
		logic       jw;
		pulse_t     jp;
	} servo_outputs_t;

	typedef struct packed {
		pulse_t pos;
		logic   moving;
	} slew_t;

	logic [7:0] claw_interval, claw_step, claw_band;
	logic [7:0] joint_interval, joint_step, joint_band;
	quant_t     claw_quant, joint_quant;

	logic [3:0] ui_count;
	logic [7:0] claw_count, joint_count;
	pulse_t     claw_cur, claw_tgt, joint_cur, joint_tgt, joint_last;
	logic       claw_mv, joint_mv;
	logic       rotating;
	logic [15:0] rot_elapsed, rot_limit;
	logic [1:0]  rot_chan;

	servo_outputs_t awaited_outputs[$];
	int unsigned    mismatches, n_ticks, n_starts, n_stops, n_claw, n_joint;

	function automatic pulse_t to_quantum(pulse_t x, quant_t q);
		int unsigned qq, r;
		qq = (q == 0) ? 1 : q;
		r = ((x + qq / 2) / qq) * qq;
		return (r > PULSE_MAX) ? PULSE_MAX : pulse_t'(r);
	endfunction

	function automatic slew_t slew_toward(pulse_t cur, pulse_t tgt, logic [7:0] step,
			logic [7:0] band);
		pulse_t gap;
		slew_t  res;
		gap = (cur > tgt) ? cur - tgt : tgt - cur;
		res.moving = 1'b1;
		if (gap <= band) begin
			res.pos = tgt;
			res.moving = 1'b0;
		end else begin
			if (gap > step)
				gap = step;
			res.pos = (cur < tgt) ? cur + gap : cur - gap;
		end
		return res;
	endfunction

	// One accepted item: either latch a timed rotation or do the work of a tick.
	function automatic servo_outputs_t advance_servo_tick(logic start,
			logic [IN_FIELD_W-1:0] f);
		servo_outputs_t r;
		slew_t          s;
		logic           manual;
		logic [1:0]     jdir, cdir;
		r = '0;
		manual = f[0];
		jdir = f[2:1];
		cdir = f[4:3];
		if (start) begin
			rotating = 1'b1;
			rot_elapsed = '0;
			rot_limit = f[20:5];
			rot_chan = f[22:21];
			return r;
		end
		ui_count = ui_count + 1'b1;
		if (ui_count >= UI_PERIOD) begin
			ui_count = '0;
			r.ui = 1'b1;
		end
		if (rotating) begin
			rot_elapsed = rot_elapsed + 1'b1;
			if (rot_elapsed >= rot_limit) begin
				rotating = 1'b0;
				r.stop = 1'b1;
				r.stop_ch = rot_chan;
			end
		end
		// A direction pattern with the top bit set counts as negative.
		if (manual) begin
			if (jdir == 2'b01) begin
				joint_tgt = JOINT_UP_US;
				joint_mv = 1'b1;
			end else if (jdir[1]) begin
				joint_tgt = JOINT_DOWN_US;
				joint_mv = 1'b1;
			end else begin
				joint_tgt = joint_cur;
				joint_mv = 1'b0;
			end
			if (cdir == 2'b01) begin
				claw_tgt = CLAW_CLOSE_US;
				claw_mv = 1'b1;
			end else if (cdir[1]) begin
				claw_tgt = CLAW_OPEN_US;
				claw_mv = 1'b1;
			end
		end
		claw_count = claw_count + 1'b1;
		if (claw_count >= claw_interval) begin
			claw_count = '0;
			if (claw_mv) begin
				s = slew_toward(claw_cur, claw_tgt, claw_step, claw_band);
				claw_cur = s.pos;
				claw_mv = s.moving;
				r.cw = 1'b1;
				r.cp = to_quantum(claw_cur, claw_quant);
			end
		end
		joint_count = joint_count + 1'b1;
		if (joint_count >= joint_interval) begin
			joint_count = '0;
			if (joint_mv) begin
				s = slew_toward(joint_cur, joint_tgt, joint_step, joint_band);
				joint_cur = s.pos;
				joint_mv = s.moving;
				r.jw = 1'b1;
				r.jp = to_quantum(joint_cur, joint_quant);
				joint_last = r.jp;
			end else begin
				joint_cur = joint_last;
				joint_tgt = joint_last;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		servo_outputs_t want;
		if (!arst_n) begin
			claw_interval = 8'd20;
			claw_step = 8'd10;
			claw_band = 8'd3;
			claw_quant = 6'd5;
			joint_interval = 8'd20;
			joint_step = 8'd10;
			joint_band = 8'd2;
			joint_quant = 6'd2;
			ui_count = '0;
			claw_count = '0;
			joint_count = '0;
			claw_cur = CLAW_OPEN_US;
			claw_tgt = CLAW_OPEN_US;
			claw_mv = 1'b0;
			joint_cur = JOINT_HOME_US;
			joint_tgt = JOINT_HOME_US;
			joint_mv = 1'b0;
			joint_last = JOINT_HOME_US;
			rotating = 1'b0;
			rot_elapsed = '0;
			rot_limit = '0;
			rot_chan = '0;
			awaited_outputs.delete();
			mismatches = 0;
			n_ticks = 0;
			n_starts = 0;
			n_stops = 0;
			n_claw = 0;
			n_joint = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CLAW_INTERVAL:  claw_interval = cfg_data;
					CFG_CLAW_STEP:      claw_step = cfg_data;
					CFG_CLAW_DEADBAND:  claw_band = cfg_data;
					CFG_CLAW_QUANT:     claw_quant = cfg_data[QUANT_BITS-1:0];
					CFG_JOINT_INTERVAL: joint_interval = cfg_data;
					CFG_JOINT_STEP:     joint_step = cfg_data;
					CFG_JOINT_DEADBAND: joint_band = cfg_data;
					CFG_JOINT_QUANT:    joint_quant = cfg_data[QUANT_BITS-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == MODE_START)
					n_starts++;
				else
					n_ticks++;
				awaited_outputs.push_back(advance_servo_tick(s_tuser,
						s_tdata[IN_FIELD_W-1:0]));
			end
			if (m_tvalid && m_tready) begin
				if (awaited_outputs.size() == 0) begin
					$error("result transaction with no prediction waiting: %h", m_tdata);
					mismatches++;
				end else begin
					want = awaited_outputs.pop_front();
					check_field("ui_update", want.ui, m_tdata[0]);
					check_field("rotate_stop", want.stop, m_tdata[1]);
					check_field("stop_channel", want.stop_ch, m_tdata[3:2]);
					check_field("claw_write", want.cw, m_tdata[4]);
					check_field("claw_pulse", want.cp, m_tdata[16:5]);
					check_field("joint_write", want.jw, m_tdata[17]);
					check_field("joint_pulse", want.jp, m_tdata[29:18]);
					n_stops += want.stop;
					n_claw += want.cw;
					n_joint += want.jw;
				end
			end
		end
		fail_count <= mismatches;
		pending <= awaited_outputs.size();
		ticks_seen <= n_ticks;
		starts_seen <= n_starts;
		stops_seen <= n_stops;
		claw_writes <= n_claw;
		joint_writes <= n_joint;
	end

endmodule

/* tb/tb_servo_slew_limiter_tick_scheduler_top.sv */
`timescale 1ns / 100ps

// Stimulus for the servo slew limiter and tick scheduler. The checker beside
// the block predicts and compares every transaction; this module only makes
// traffic, programs the registers between phases and gives the verdict.
module tb_servo_slew_limiter_tick_scheduler_top;
	import sslts_pkg::*;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_START = 1'b1;
	// A correct run ends well short of this limit, so it only trips on a hang.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic                    s_tuser = 1'b0;
	logic [IN_DATA_W-1:0]    s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_data = '0;

	int unsigned fail_count, pending, ticks_seen, starts_seen;
	int unsigned stops_seen, claw_writes, joint_writes;
	int unsigned cycle_count = 0;
	int unsigned ready_hold = 0;
	// When set, the sender never idles, so items follow one another at the
	// block's own pace.
	bit          eager = 1'b0;
	// Manual directions persist over runs of ticks so that the pulses have
	// time to travel all the way to their end points.
	logic [1:0]  joint_hold_dir = 2'b00;
	logic [1:0]  claw_hold_dir = 2'b00;

	servo_slew_limiter_tick_scheduler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	servo_tick_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tuser      (s_tuser),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.ticks_seen   (ticks_seen),
		.starts_seen  (starts_seen),
		.stops_seen   (stops_seen),
		.claw_writes  (claw_writes),
		.joint_writes (joint_writes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hang guard. A run that is still going at the limit has lost a
	// transaction somewhere, which is a failure in its own right.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
					cycle_count, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver holds tready for stretches of random length: mostly short
	// stalls and short open windows, now and then a long stall, and now and
	// then a long open stretch with no back-pressure at all.
	always @(posedge clk) begin : receiver
		int unsigned pick;
		logic        next_ready;
		int unsigned span;
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				next_ready = 1'b1;
				span = $urandom_range(0, 8);
			end else if (pick < 88) begin
				next_ready = 1'b0;
				span = $urandom_range(0, 3);
			end else if (pick < 96) begin
				next_ready = 1'b0;
				span = $urandom_range(8, 40);
			end else begin
				next_ready = 1'b1;
				span = $urandom_range(50, 200);
			end
			m_tready <= next_ready;
			ready_hold <= span;
		end
	end

	// Idle cycles before the next item: mostly none or a few, so that gaps
	// land at every point of the block's work on an item, and a few long ones.
	function automatic int unsigned sender_gap();
		int unsigned pick;
		if (eager)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		if (pick < 75)
			return $urandom_range(1, 4);
		if (pick < 95)
			return $urandom_range(5, 20);
		return $urandom_range(21, 60);
	endfunction

	// Offers one item and returns at the edge where its transaction happens.
	// tvalid stays high afterwards, so that back-to-back items need no second
	// assignment within one time step.
	task automatic send_item(input logic mode, input logic manual, input logic [1:0] jdir,
			input logic [1:0] cdir, input logic [15:0] ms, input logic [1:0] chan);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {1'b0, chan, ms, cdir, jdir, manual};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// The block must be idle before its registers are touched. pending is
	// one edge behind, hence the edge before the first look.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic apply_config(input logic [7:0] c_int, input logic [7:0] c_step,
			input logic [7:0] c_band, input logic [7:0] c_quant, input logic [7:0] j_int,
			input logic [7:0] j_step, input logic [7:0] j_band, input logic [7:0] j_quant);
		put_reg(CFG_CLAW_INTERVAL, c_int);
		put_reg(CFG_CLAW_STEP, c_step);
		put_reg(CFG_CLAW_DEADBAND, c_band);
		put_reg(CFG_CLAW_QUANT, c_quant);
		put_reg(CFG_JOINT_INTERVAL, j_int);
		put_reg(CFG_JOINT_STEP, j_step);
		put_reg(CFG_JOINT_DEADBAND, j_band);
		put_reg(CFG_JOINT_QUANT, j_quant);
		cfg_valid <= 1'b0;
	endtask

	// Mostly manual ticks that hold a direction for a while, some ticks with
	// manual control off, some noisy directions, and the odd rotation start
	// with a duration that is usually short enough to end within the phase.
	task automatic random_item();
		int unsigned pick;
		logic [15:0] ms;
		logic [1:0]  chan;
		pick = $urandom_range(0, 99);
		chan = 2'($urandom);
		if (pick < 7) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				ms = 16'($urandom_range(0, 30));
			else if (pick < 9)
				ms = 16'($urandom_range(0, 300));
			else
				ms = 16'($urandom);
			send_item(MODE_START, 1'($urandom), 2'($urandom), 2'($urandom), ms, chan);
		end else begin
			if ($urandom_range(0, 24) == 0)
				joint_hold_dir = 2'($urandom);
			if ($urandom_range(0, 24) == 0)
				claw_hold_dir = 2'($urandom);
			ms = 16'($urandom);
			if (pick < 80)
				send_item(MODE_TICK, 1'b1, joint_hold_dir, claw_hold_dir, ms, chan);
			else if (pick < 90)
				send_item(MODE_TICK, 1'b0, 2'($urandom), 2'($urandom), ms, chan);
			else
				send_item(MODE_TICK, 1'b1, 2'($urandom), 2'($urandom), ms, chan);
		end
	endtask

	task automatic run_random(input int unsigned count);
		repeat (count) random_item();
	endtask

	initial begin : stimulus
		int unsigned phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings. A start with a zero limit
		// stops on the very next tick; the rotation fields of a tick are
		// ignored, so they carry all ones here.
		send_item(MODE_START, 1'b0, 2'b00, 2'b00, 16'h0000, 2'd3);
		send_item(MODE_TICK, 1'b0, 2'b00, 2'b00, 16'hFFFF, 2'd3);
		// A long rotation, then a restart with a short one before it ends.
		send_item(MODE_START, 1'b1, 2'b11, 2'b11, 16'hFFFF, 2'd0);
		send_item(MODE_TICK, 1'b0, 2'b00, 2'b00, 16'h0000, 2'd0);
		send_item(MODE_START, 1'b0, 2'b00, 2'b00, 16'h0002, 2'd2);
		send_item(MODE_TICK, 1'b0, 2'b00, 2'b00, 16'h0000, 2'd0);
		send_item(MODE_TICK, 1'b0, 2'b00, 2'b00, 16'h0000, 2'd0);
		// Every direction pattern, including the minus-two pattern, then a
		// hold, then directions with manual control switched off.
		send_item(MODE_TICK, 1'b1, 2'b01, 2'b01, 16'h0000, 2'd0);
		send_item(MODE_TICK, 1'b1, 2'b10, 2'b10, 16'h0000, 2'd0);
		send_item(MODE_TICK, 1'b1, 2'b11, 2'b11, 16'h0000, 2'd0);
		send_item(MODE_TICK, 1'b1, 2'b00, 2'b00, 16'h0000, 2'd0);
		send_item(MODE_TICK, 1'b0, 2'b01, 2'b01, 16'h0000, 2'd0);
		send_item(MODE_START, 1'b0, 2'b00, 2'b00, 16'h5555, 2'd1);
		send_item(MODE_START, 1'b1, 2'b00, 2'b00, 16'hAAAA, 2'd2);
		// Keep the joint going up and the claw opening through all but the last
		// tick of the first smoothing interval.
		repeat (10) send_item(MODE_TICK, 1'b1, 2'b01, 2'b10, 16'h0000, 2'd0);

		// Fastest and finest: every tick updates, full step, no dead band,
		// no rounding.
		wait_drained();
		apply_config(8'd1, 8'd255, 8'd0, 8'd1, 8'd1, 8'd255, 8'd0, 8'd1);
		run_random(250);

		// Zero interval, zero step, widest dead band, and a quantum whose
		// six kept bits are all zero.
		wait_drained();
		apply_config(8'd0, 8'd0, 8'd255, 8'hC0, 8'd0, 8'd0, 8'd255, 8'hC0);
		run_random(200);

		// Slowest and coarsest settings.
		wait_drained();
		apply_config(8'd255, 8'd255, 8'd255, 8'd63, 8'd255, 8'd255, 8'd255, 8'd63);
		run_random(150);

		// Random settings. The first of these usually lowers the interval
		// below a count that has grown large in the slow phase.
		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			eager = (phase == 2);
			apply_config(
				($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6)) :
						8'($urandom_range(0, 40)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
				8'($urandom_range(0, 20)),
				8'($urandom),
				($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6)) :
						8'($urandom_range(0, 40)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
				8'($urandom_range(0, 20)),
				8'($urandom));
			run_random(200);
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Covered %0d ticks and %0d rotation starts over ten register settings,",
				ticks_seen, starts_seen);
		$display("with %0d rotation stops, %0d claw writes and %0d joint writes checked.",
				stops_seen, claw_writes, joint_writes);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d field mismatches in total.", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
